// ----- src/drs_pkg.sv -----
// ----------------------------------------------------------------------------
// drs_pkg
// shared codes and constants for the diagnostic request server
// ----------------------------------------------------------------------------
package drs_pkg;

	localparam int unsigned NumBytes = 6;

	typedef logic [7:0] byte_t;

	typedef enum logic [1:0] {
		OP_REQUEST = 2'd0,
		OP_COMMIT  = 2'd1,
		OP_RESET   = 2'd2,
		OP_NONE    = 2'd3
	} op_t;

	// service identifiers
	localparam byte_t SID_SESSION  = 8'h10;
	localparam byte_t SID_READ     = 8'h22;
	localparam byte_t SID_SECURITY = 8'h27;
	localparam byte_t SID_WRITE    = 8'h2E;
	localparam byte_t SID_ROUTINE  = 8'h31;
	localparam byte_t SID_PRESENT  = 8'h3E;

	// positive response offset and negative marker
	localparam byte_t POS_OFFSET = 8'h40;
	localparam byte_t NEG_MARK   = 8'h7F;

	// negative response codes
	localparam byte_t NRC_SERVICE    = 8'h11;
	localparam byte_t NRC_SUBFUNC    = 8'h12;
	localparam byte_t NRC_LENGTH     = 8'h13;
	localparam byte_t NRC_CONDITIONS = 8'h22;
	localparam byte_t NRC_SEQUENCE   = 8'h24;
	localparam byte_t NRC_RANGE      = 8'h31;
	localparam byte_t NRC_SECURITY   = 8'h33;
	localparam byte_t NRC_KEY        = 8'h35;
	localparam byte_t NRC_SESSION    = 8'h7F;

	// subfunctions
	localparam byte_t SUB_DEFAULT  = 8'h01;
	localparam byte_t SUB_EXTENDED = 8'h03;
	localparam byte_t SUB_SEED     = 8'h01;
	localparam byte_t SUB_KEY      = 8'h02;
	localparam byte_t SUB_START    = 8'h01;

	// identifiers, seed and key
	localparam logic [15:0] CODING_ID  = 16'hF1A0;
	localparam logic [15:0] APPLY_ID   = 16'hFF10;
	localparam logic [15:0] SEED_VALUE = 16'h5A3C;
	localparam logic [15:0] KEY_MASK   = 16'hA55A;
	localparam logic [15:0] KEY_VALUE  = SEED_VALUE ^ KEY_MASK;

	// session timing parameters echoed in the session response
	localparam byte_t P2_HI      = 8'h00;
	localparam byte_t P2_LO      = 8'h32;
	localparam byte_t P2_EXT_HI  = 8'h01;
	localparam byte_t P2_EXT_LO  = 8'hF4;

	// largest allowed value of each coding record byte
	localparam byte_t REC0_MAX = 8'd1;
	localparam byte_t REC1_MAX = 8'd2;
	localparam byte_t REC2_MAX = 8'd1;

endpackage

// ----- src/diagnostic_request_server.sv -----
// ----------------------------------------------------------------------------
// diagnostic_request_server
// serves one whole diagnostic request per cycle unless out_ready stalls: session, security access,
// coding record read/write, apply routine, tester present, commit and reset
// ----------------------------------------------------------------------------
// path: an accepted request passes from the input register through the decode
//   stage into the response register, which out_ready can stall
// throughput: one request per cycle unless out_ready stalls, set by the single
//   decode stage between the input register and the response register
// reset: arst_n clears session, security flags, record flags, both coding
//   records and the valid bits of both stages
module diagnostic_request_server
	import drs_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_ready,
	input  logic [1:0] operation,
	input  logic [7:0] req_length,
	input  logic [7:0] req_byte_0,
	input  logic [7:0] req_byte_1,
	input  logic [7:0] req_byte_2,
	input  logic [7:0] req_byte_3,
	input  logic [7:0] req_byte_4,
	input  logic [7:0] req_byte_5,
	output logic       out_valid,
	input  logic       out_ready,
	output logic [2:0] resp_length,
	output logic [7:0] resp_byte_0,
	output logic [7:0] resp_byte_1,
	output logic [7:0] resp_byte_2,
	output logic [7:0] resp_byte_3,
	output logic [7:0] resp_byte_4,
	output logic [7:0] resp_byte_5
);

	// input register
	logic       valid_s1;
	op_t        op_s1;
	logic [7:0] len_s1;
	byte_t      byte_s1 [NumBytes];

	// response register
	logic       valid_s2;
	logic [2:0] len_s2;
	byte_t      byte_s2 [NumBytes];

	// server state
	logic  ext_session_q, unlocked_q, seed_sent_q, rec_valid_q, commit_pend_q;
	byte_t work_rec_q  [3];
	byte_t store_rec_q [3];

	// next state and response from the decode stage
	logic  ext_session_d, unlocked_d, seed_sent_d, rec_valid_d, commit_pend_d;
	byte_t work_rec_d  [3];
	byte_t store_rec_d [3];
	logic [2:0] rsp_len;
	byte_t      rsp     [NumBytes];
	byte_t      q       [NumBytes];
	logic       is_neg;
	byte_t      nrc;
	logic       coding_id_ok;
	logic [15:0] word_23;

	logic advance_s1;

	// response register frees when empty or being taken
	assign advance_s1 = valid_s1 && (!valid_s2 || out_ready);
	assign in_ready   = !valid_s1 || advance_s1;

	// ---------------------------------------------------------------- stage 1
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			op_s1      <= op_t'(operation);
			len_s1     <= req_length;
			byte_s1[0] <= req_byte_0;
			byte_s1[1] <= req_byte_1;
			byte_s1[2] <= req_byte_2;
			byte_s1[3] <= req_byte_3;
			byte_s1[4] <= req_byte_4;
			byte_s1[5] <= req_byte_5;
		end
	end

	// ---------------------------------------------------------------- decode
	// bytes at or past the request length read as zero
	always_comb begin
		for (int i = 0; i < NumBytes; i++) begin
			q[i] = (8'(i) < len_s1) ? byte_s1[i] : 8'h00;
		end
	end

	assign coding_id_ok = ({q[1], q[2]} == CODING_ID);
	assign word_23      = {q[2], q[3]};

	always_comb begin
		ext_session_d = ext_session_q;
		unlocked_d    = unlocked_q;
		seed_sent_d   = seed_sent_q;
		rec_valid_d   = rec_valid_q;
		commit_pend_d = commit_pend_q;
		work_rec_d    = work_rec_q;
		store_rec_d   = store_rec_q;
		rsp_len       = 3'd0;
		is_neg        = 1'b0;
		nrc           = NRC_SERVICE;
		for (int i = 0; i < NumBytes; i++) begin
			rsp[i] = 8'h00;
		end

		unique case (op_s1)
			OP_REQUEST: begin
				if (len_s1 != 8'd0) begin
					unique case (q[0])
						SID_SESSION: begin
							priority if (len_s1 != 8'd2) begin
								is_neg = 1'b1;
								nrc    = NRC_LENGTH;
							end else if (q[1] != SUB_DEFAULT && q[1] != SUB_EXTENDED) begin
								is_neg = 1'b1;
								nrc    = NRC_SUBFUNC;
							end else begin
								ext_session_d = (q[1] == SUB_EXTENDED);
								unlocked_d    = 1'b0;
								seed_sent_d   = 1'b0;
								rsp_len       = 3'd6;
								rsp[0]        = SID_SESSION + POS_OFFSET;
								rsp[1]        = q[1];
								rsp[2]        = P2_HI;
								rsp[3]        = P2_LO;
								rsp[4]        = P2_EXT_HI;
								rsp[5]        = P2_EXT_LO;
							end
						end
						SID_READ: begin
							priority if (len_s1 != 8'd3) begin
								is_neg = 1'b1;
								nrc    = NRC_LENGTH;
							end else if (!coding_id_ok) begin
								is_neg = 1'b1;
								nrc    = NRC_RANGE;
							end else begin
								rsp_len = 3'd6;
								rsp[0]  = SID_READ + POS_OFFSET;
								rsp[1]  = q[1];
								rsp[2]  = q[2];
								rsp[3]  = work_rec_q[0];
								rsp[4]  = work_rec_q[1];
								rsp[5]  = work_rec_q[2];
							end
						end
						SID_SECURITY: begin
							priority if (!ext_session_q) begin
								is_neg = 1'b1;
								nrc    = NRC_SESSION;
							end else if (len_s1 == 8'd2 && q[1] == SUB_SEED) begin
								seed_sent_d = 1'b1;
								rsp_len     = 3'd4;
								rsp[0]      = SID_SECURITY + POS_OFFSET;
								rsp[1]      = SUB_SEED;
								rsp[2]      = SEED_VALUE[15:8];
								rsp[3]      = SEED_VALUE[7:0];
							end else if (len_s1 != 8'd4 || q[1] != SUB_KEY) begin
								is_neg = 1'b1;
								nrc    = NRC_LENGTH;
							end else if (!seed_sent_q) begin
								is_neg = 1'b1;
								nrc    = NRC_SEQUENCE;
							end else if (word_23 != KEY_VALUE) begin
								is_neg = 1'b1;
								nrc    = NRC_KEY;
							end else begin
								unlocked_d  = 1'b1;
								seed_sent_d = 1'b0;
								rsp_len     = 3'd2;
								rsp[0]      = SID_SECURITY + POS_OFFSET;
								rsp[1]      = SUB_KEY;
							end
						end
						SID_WRITE: begin
							priority if (len_s1 != 8'd6) begin
								is_neg = 1'b1;
								nrc    = NRC_LENGTH;
							end else if (!coding_id_ok) begin
								is_neg = 1'b1;
								nrc    = NRC_RANGE;
							end else if (!ext_session_q) begin
								is_neg = 1'b1;
								nrc    = NRC_SESSION;
							end else if (!unlocked_q) begin
								is_neg = 1'b1;
								nrc    = NRC_SECURITY;
							end else if (q[3] > REC0_MAX || q[4] > REC1_MAX
									|| q[5] > REC2_MAX) begin
								is_neg = 1'b1;
								nrc    = NRC_RANGE;
							end else begin
								work_rec_d[0] = q[3];
								work_rec_d[1] = q[4];
								work_rec_d[2] = q[5];
								rec_valid_d   = 1'b1;
								commit_pend_d = 1'b1;
								rsp_len       = 3'd3;
								rsp[0]        = SID_WRITE + POS_OFFSET;
								rsp[1]        = q[1];
								rsp[2]        = q[2];
							end
						end
						SID_ROUTINE: begin
							priority if (len_s1 != 8'd4) begin
								is_neg = 1'b1;
								nrc    = NRC_LENGTH;
							end else if (word_23 != APPLY_ID || q[1] != SUB_START) begin
								is_neg = 1'b1;
								nrc    = NRC_RANGE;
							end else if (!rec_valid_q) begin
								is_neg = 1'b1;
								nrc    = NRC_CONDITIONS;
							end else begin
								rsp_len = 3'd5;
								rsp[0]  = SID_ROUTINE + POS_OFFSET;
								rsp[1]  = SUB_START;
								rsp[2]  = APPLY_ID[15:8];
								rsp[3]  = APPLY_ID[7:0];
							end
						end
						SID_PRESENT: begin
							if (len_s1 != 8'd2) begin
								is_neg = 1'b1;
								nrc    = NRC_LENGTH;
							end else begin
								rsp_len = 3'd2;
								rsp[0]  = SID_PRESENT + POS_OFFSET;
								rsp[1]  = q[1];
							end
						end
						default: begin
							is_neg = 1'b1;
							nrc    = NRC_SERVICE;
						end
					endcase
				end
			end
			OP_COMMIT: begin
				// save the working record only when a write is outstanding
				if (commit_pend_q) begin
					store_rec_d   = work_rec_q;
					commit_pend_d = 1'b0;
				end
			end
			OP_RESET: begin
				// simulated ecu reset: back to default session, record restored
				ext_session_d = 1'b0;
				unlocked_d    = 1'b0;
				seed_sent_d   = 1'b0;
				work_rec_d    = store_rec_q;
			end
			OP_NONE: begin
			end
		endcase

		// three-byte negative response overrides everything else
		if (is_neg) begin
			rsp_len = 3'd3;
			rsp[0]  = NEG_MARK;
			rsp[1]  = q[0];
			rsp[2]  = nrc;
			rsp[3]  = 8'h00;
			rsp[4]  = 8'h00;
			rsp[5]  = 8'h00;
		end
	end

	// ---------------------------------------------------------------- state
	// state moves only when a request leaves the decode stage, so the next
	// request in line always sees the outcome of the previous one
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ext_session_q <= 1'b0;
			unlocked_q    <= 1'b0;
			seed_sent_q   <= 1'b0;
			rec_valid_q   <= 1'b0;
			commit_pend_q <= 1'b0;
			for (int i = 0; i < 3; i++) begin
				work_rec_q[i]  <= 8'h00;
				store_rec_q[i] <= 8'h00;
			end
		end else if (advance_s1) begin
			ext_session_q <= ext_session_d;
			unlocked_q    <= unlocked_d;
			seed_sent_q   <= seed_sent_d;
			rec_valid_q   <= rec_valid_d;
			commit_pend_q <= commit_pend_d;
			work_rec_q    <= work_rec_d;
			store_rec_q   <= store_rec_d;
		end
	end

	// ---------------------------------------------------------------- stage 2
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (advance_s1) begin
			valid_s2 <= 1'b1;
		end else if (out_ready) begin
			valid_s2 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance_s1) begin
			len_s2  <= rsp_len;
			byte_s2 <= rsp;
		end
	end

	assign out_valid   = valid_s2;
	assign resp_length = len_s2;
	assign resp_byte_0 = byte_s2[0];
	assign resp_byte_1 = byte_s2[1];
	assign resp_byte_2 = byte_s2[2];
	assign resp_byte_3 = byte_s2[3];
	assign resp_byte_4 = byte_s2[4];
	assign resp_byte_5 = byte_s2[5];

`ifndef SYNTHESIS
	// a pending commit always refers to a record that has been written
	a_pend_has_record: assert property (@(posedge clk) disable iff (!arst_n)
		commit_pend_q |-> rec_valid_q)
		else $error("commit pending without a valid record");

	// unlock is only reachable and kept inside the extended session
	a_unlock_in_ext: assert property (@(posedge clk) disable iff (!arst_n)
		unlocked_q |-> ext_session_q)
		else $error("unlocked outside the extended session");

	// a request leaving the decode stage shows up as a response next cycle
	a_advance_resp: assert property (@(posedge clk) disable iff (!arst_n)
		advance_s1 |=> out_valid)
		else $error("decoded request produced no response");

	// empty responses carry no bytes
	a_empty_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && resp_length == 3'd0) |-> (resp_byte_0 == 8'h00
			&& resp_byte_1 == 8'h00 && resp_byte_2 == 8'h00))
		else $error("empty response with non-zero bytes");
`endif

endmodule
